// File: rtl/drc_pkg.sv
// Shared types, constants and helpers for the delta regression block.
// Used by drc_ctrl, drc_dp and delta_regression_coefficients; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package drc_pkg;

  // Defaults for the top-level parameters
  localparam int unsigned MAX_HALF_WINDOW_DEF = 4;
  localparam int unsigned MAX_COEFFS_DEF      = 64;
  localparam int unsigned SAMPLE_BITS_DEF     = 16;

  // Largest half window any build may use
  localparam int unsigned HW_LIMIT = 8;

  // Register widths and reset values
  localparam int unsigned WIN_W      = 3;
  localparam int unsigned COEFFS_W   = 7;
  localparam int unsigned CFG_DATA_W = 7;
  localparam int unsigned CFG_ADDR_W = 1;
  localparam int unsigned IDX_W      = 6;

  localparam logic [WIN_W-1:0]    WIN_RESET    = 3'd2;
  localparam logic [COEFFS_W-1:0] COEFFS_RESET = 7'd13;

  // Register map
  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_WINDOW = 1'b0,
    REG_COEFFS = 1'b1
  } cfg_reg_e;

  // Controller to datapath commands
  typedef struct packed {
    logic load_item;
    logic rd_en;
    logic mac_en;
    logic div_prep;
    logic div_step;
    logic out_load;
  } drc_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic item_emit;
    logic n_zero;
    logic tap_last;
    logic out_free;
  } drc_status_t;

  // Divisor for half window n: 2 * sum of i*i over i = 1..n
  function automatic int unsigned tap_norm(int unsigned n);
    int unsigned sum;
    sum = 0;
    for (int unsigned i = 1; i <= HW_LIMIT; i++) begin
      if (i <= n) begin
        sum = sum + 2 * i * i;
      end
    end
    return sum;
  endfunction

endpackage

`default_nettype wire

// File: rtl/delta_regression_coefficients.sv
// Delta regression over a stream of feature coefficients.
// Coefficients enter on s_axis (tdata: sample_value; tuser: start_of_stream), one per beat.
// Deltas leave on m_axis (tdata: delta_value; tuser: coeff_index; tlast: frame_end).
// Registers are written on the cfg channel: index 0 half window, index 1 coeffs per frame.
// With half window n > 0, a beat for coefficient k of frame t gives delta k of frame t-n;
// no output appears until frame n has begun. Half window 0 gives the first difference.
// Work per item: the beat is taken, then each tap is read from the dual-read frame ring
// and accumulated, the serial divider is set up and run one quotient bit at a time,
// and the result goes into the output register. Window 0 skips the divider; items that
// give no result end once the beat is taken.
// One item is in work at a time; the next beat is taken while a result still waits in
// the output register, and a stalled receiver only holds the block once a second result
// is ready. Reset empties the output register and clears position, ring pointer and
// frame count; the frame ring itself is not cleared and needs no clearing pass.
// Depends on drc_pkg, drc_ctrl and drc_dp.
`timescale 1ns / 1ps
`default_nettype none

module delta_regression_coefficients #(
  parameter int unsigned MAX_HALF_WINDOW = drc_pkg::MAX_HALF_WINDOW_DEF,
  parameter int unsigned MAX_COEFFS      = drc_pkg::MAX_COEFFS_DEF,
  parameter int unsigned SAMPLE_BITS     = drc_pkg::SAMPLE_BITS_DEF,
  localparam int unsigned TDATA_W        = ((SAMPLE_BITS + 7) / 8) * 8
) (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  // configuration writes
  input  wire                              cfg_valid_i,
  output logic                             cfg_ready_o,
  input  wire [drc_pkg::CFG_ADDR_W-1:0]    cfg_addr_i,
  input  wire [drc_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  // input stream
  input  wire                              s_axis_tvalid,
  output logic                             s_axis_tready,
  input  wire [TDATA_W-1:0]                s_axis_tdata,   // sample_value
  input  wire                              s_axis_tuser,   // start_of_stream
  // output stream
  output logic                             m_axis_tvalid,
  input  wire                              m_axis_tready,
  output logic [TDATA_W-1:0]               m_axis_tdata,   // delta_value
  output logic [drc_pkg::IDX_W-1:0]        m_axis_tuser,   // coeff_index
  output logic                             m_axis_tlast    // frame_end
);

  logic [drc_pkg::WIN_W-1:0]    win_q;
  logic [drc_pkg::COEFFS_W-1:0] coeffs_q;

  drc_pkg::drc_cmd_t    cmd;
  drc_pkg::drc_status_t status;

  logic signed [SAMPLE_BITS-1:0] out_delta;

  // Configuration registers, always ready
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q    <= drc_pkg::WIN_RESET;
      coeffs_q <= drc_pkg::COEFFS_RESET;
    end else if (cfg_valid_i) begin
      unique case (drc_pkg::cfg_reg_e'(cfg_addr_i))
        drc_pkg::REG_WINDOW: win_q    <= cfg_data_i[drc_pkg::WIN_W-1:0];
        drc_pkg::REG_COEFFS: coeffs_q <= cfg_data_i[drc_pkg::COEFFS_W-1:0];
        default: ;
      endcase
    end
  end

  drc_ctrl #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(s_axis_tvalid),
    .in_ready_o(s_axis_tready),
    .status_i  (status),
    .cmd_o     (cmd)
  );

  drc_dp #(
    .MAX_HALF_WINDOW(MAX_HALF_WINDOW),
    .MAX_COEFFS     (MAX_COEFFS),
    .SAMPLE_BITS    (SAMPLE_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .cfg_window_i(win_q),
    .cfg_coeffs_i(coeffs_q),
    .in_sample_i (s_axis_tdata[SAMPLE_BITS-1:0]),
    .in_sos_i    (s_axis_tuser),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_delta_o (out_delta),
    .out_index_o (m_axis_tuser),
    .out_last_o  (m_axis_tlast)
  );

  // Zero fill of the result to whole bytes
  assign m_axis_tdata = TDATA_W'($unsigned(out_delta));

endmodule

`default_nettype wire

// File: rtl/drc_ctrl.sv
// Sequencer for the delta regression block: read, multiply-accumulate, divide, output.
// Depends on drc_pkg for the command and status structs.
`timescale 1ns / 1ps
`default_nettype none

module drc_ctrl #(
  parameter int unsigned SAMPLE_BITS = drc_pkg::SAMPLE_BITS_DEF
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 in_valid_i,
  output logic                in_ready_o,
  input  drc_pkg::drc_status_t status_i,
  output drc_pkg::drc_cmd_t   cmd_o
);

  localparam int unsigned DCNT_W = $clog2(SAMPLE_BITS);
  localparam logic [DCNT_W-1:0] DCNT_LAST = DCNT_W'(SAMPLE_BITS - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_MAC,
    S_PREP,
    S_DIV,
    S_OUT
  } state_e;

  state_e            state_q;
  logic [DCNT_W-1:0] div_cnt_q;

  // Commands decoded from the state
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o      = 1'b1;
        cmd_o.load_item = in_valid_i;
      end
      S_READ: cmd_o.rd_en    = 1'b1;
      S_MAC:  cmd_o.mac_en   = 1'b1;
      S_PREP: cmd_o.div_prep = 1'b1;
      S_DIV:  cmd_o.div_step = 1'b1;
      S_OUT:  cmd_o.out_load = status_i.out_free;
      default: ;
    endcase
  end

  // State and divide step counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      div_cnt_q <= '0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i && status_i.item_emit) begin
            state_q <= S_READ;
          end
        end
        S_READ: state_q <= S_MAC;
        S_MAC: begin
          if (!status_i.tap_last) begin
            state_q <= S_READ;
          end else if (status_i.n_zero) begin
            state_q <= S_OUT;
          end else begin
            state_q <= S_PREP;
          end
        end
        S_PREP: begin
          div_cnt_q <= '0;
          state_q   <= S_DIV;
        end
        S_DIV: begin
          div_cnt_q <= div_cnt_q + DCNT_W'(1);
          if (div_cnt_q == DCNT_LAST) begin
            state_q <= S_OUT;
          end
        end
        S_OUT: begin
          if (status_i.out_free) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

`ifndef ASSERT_OFF
  // Every accumulate uses data fetched in the cycle before
  a_mac_after_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.mac_en |-> $past(cmd_o.rd_en))
    else $error("accumulate without a preceding read");

  // An item that gives no result leaves the block ready at once
  a_silent_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.load_item && !status_i.item_emit) |=> in_ready_o)
    else $error("silent item held the input");

  // Window zero never goes through the divider
  a_no_div_w0: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.div_prep |-> !status_i.n_zero)
    else $error("divider started with window zero");
`endif

endmodule

`default_nettype wire

// File: rtl/drc_dp.sv
// Datapath: frame ring memory, frame bookkeeping, tap accumulator, serial divider
// and output register. Depends on drc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module drc_dp #(
  parameter int unsigned MAX_HALF_WINDOW = drc_pkg::MAX_HALF_WINDOW_DEF,
  parameter int unsigned MAX_COEFFS      = drc_pkg::MAX_COEFFS_DEF,
  parameter int unsigned SAMPLE_BITS     = drc_pkg::SAMPLE_BITS_DEF
) (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  input  drc_pkg::drc_cmd_t                 cmd_i,
  output drc_pkg::drc_status_t              status_o,
  input  wire [drc_pkg::WIN_W-1:0]          cfg_window_i,
  input  wire [drc_pkg::COEFFS_W-1:0]       cfg_coeffs_i,
  input  wire signed [SAMPLE_BITS-1:0]      in_sample_i,
  input  wire                               in_sos_i,
  input  wire                               out_ready_i,
  output logic                              out_valid_o,
  output logic signed [SAMPLE_BITS-1:0]     out_delta_o,
  output logic [drc_pkg::IDX_W-1:0]         out_index_o,
  output logic                              out_last_o
);

  localparam int unsigned RING   = 2 * MAX_HALF_WINDOW + 1;
  localparam int unsigned SLOT_W = $clog2(RING);
  localparam int unsigned POS_W  = (MAX_COEFFS > 1) ? $clog2(MAX_COEFFS) : 1;
  localparam int unsigned CNT_W  = $clog2(MAX_COEFFS + 1);
  localparam int unsigned FR_W   = $clog2(2 * MAX_HALF_WINDOW + 1);
  localparam int unsigned TAP_W  = $clog2(MAX_HALF_WINDOW + 1);
  localparam int unsigned ACC_W  =
    SAMPLE_BITS + 2 + $clog2(MAX_HALF_WINDOW * (MAX_HALF_WINDOW + 1) / 2 + 1);
  localparam int unsigned DIV_W  = $clog2(drc_pkg::tap_norm(MAX_HALF_WINDOW) + 1);
  localparam int unsigned ADDR_W = SLOT_W + POS_W;
  localparam int unsigned DEPTH  = RING * (1 << POS_W);
  localparam int unsigned PROD_W = TAP_W + SAMPLE_BITS + 2;

  localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(2 ** (SAMPLE_BITS - 1) - 1);
  localparam logic signed [ACC_W-1:0] SAT_LO = -SAT_HI - ACC_W'(1);

  // Ring slot that lies 'back' frames behind 'newest'
  function automatic logic [SLOT_W-1:0] ring_slot(logic [SLOT_W-1:0] newest,
                                                  logic [FR_W-1:0] back);
    logic [SLOT_W:0] s;
    s = {1'b0, newest} + (SLOT_W+1)'(RING) - (SLOT_W+1)'(back);
    if (s >= (SLOT_W+1)'(RING)) begin
      s = s - (SLOT_W+1)'(RING);
    end
    return s[SLOT_W-1:0];
  endfunction

  // Frame bookkeeping
  logic [POS_W-1:0]  pos_q;
  logic [SLOT_W-1:0] slot_q;
  logic [FR_W-1:0]   fr_q;

  // Item under work
  logic [POS_W-1:0]  item_pos_q;
  logic [SLOT_W-1:0] item_slot_q;
  logic [FR_W-1:0]   item_fr_q;
  logic              item_last_q;
  logic [TAP_W-1:0]  n_q;
  logic [TAP_W-1:0]  tap_q;

  // Memory and read data
  logic signed [SAMPLE_BITS-1:0] frame_history [DEPTH];
  logic signed [SAMPLE_BITS-1:0] rd_new_q;
  logic signed [SAMPLE_BITS-1:0] rd_old_q;
  logic                          old_ok_q;

  // Accumulator and divider
  logic signed [ACC_W-1:0]   acc_q;
  logic [DIV_W-1:0]          rem_q;
  logic [SAMPLE_BITS-1:0]    quo_q;
  logic                      neg_q;

  // Output register
  logic                          out_valid_q;
  logic signed [SAMPLE_BITS-1:0] out_delta_q;
  logic [drc_pkg::IDX_W-1:0]     out_index_q;
  logic                          out_last_q;

  // Accept-side decode
  logic [POS_W-1:0] pos_eff;
  logic [FR_W-1:0]  fr_eff;
  logic [TAP_W-1:0] n_cfg;
  logic [CNT_W-1:0] count_eff;
  logic             last;
  logic             emit;

  always_comb begin
    pos_eff = in_sos_i ? '0 : pos_q;
    fr_eff  = in_sos_i ? '0 : fr_q;
    if (int'(cfg_window_i) > int'(MAX_HALF_WINDOW)) begin
      n_cfg = TAP_W'(MAX_HALF_WINDOW);
    end else begin
      n_cfg = TAP_W'(cfg_window_i);
    end
    if (cfg_coeffs_i == '0) begin
      count_eff = CNT_W'(1);
    end else if (int'(cfg_coeffs_i) > int'(MAX_COEFFS)) begin
      count_eff = CNT_W'(MAX_COEFFS);
    end else begin
      count_eff = CNT_W'(cfg_coeffs_i);
    end
    last = ({1'b0, CNT_W'(pos_eff)} + (CNT_W+1)'(1)) >= {1'b0, count_eff};
    emit = (n_cfg == '0) || (fr_eff >= FR_W'(n_cfg));
  end

  // Position, ring slot and frame count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      slot_q <= '0;
      fr_q   <= '0;
    end else if (cmd_i.load_item) begin
      if (last) begin
        pos_q  <= '0;
        slot_q <= (slot_q == SLOT_W'(RING - 1)) ? '0 : slot_q + SLOT_W'(1);
        fr_q   <= (fr_eff == FR_W'(2 * MAX_HALF_WINDOW)) ? fr_eff : fr_eff + FR_W'(1);
      end else begin
        pos_q  <= pos_eff + POS_W'(1);
        fr_q   <= fr_eff;
      end
    end
  end

  // Snapshot of the accepted item
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      item_pos_q  <= pos_eff;
      item_slot_q <= slot_q;
      item_fr_q   <= fr_eff;
      item_last_q <= last;
      n_q         <= n_cfg;
    end
  end

  // Tap counter, runs 1..n (a single tap for window zero)
  logic tap_last;
  assign tap_last = (n_q == '0) || (tap_q == n_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tap_q <= TAP_W'(1);
    end else if (cmd_i.load_item) begin
      tap_q <= TAP_W'(1);
    end else if (cmd_i.mac_en && !tap_last) begin
      tap_q <= tap_q + TAP_W'(1);
    end
  end

  // Tap addresses: newer frame n-i back, older frame n+i back
  logic [FR_W-1:0]   back_new;
  logic [FR_W-1:0]   back_old;
  logic [ADDR_W-1:0] addr_new;
  logic [ADDR_W-1:0] addr_old;
  logic              old_ok;

  always_comb begin
    if (n_q == '0) begin
      back_new = '0;
      back_old = FR_W'(1);
    end else begin
      back_new = FR_W'(n_q) - FR_W'(tap_q);
      back_old = FR_W'(n_q) + FR_W'(tap_q);
    end
    addr_new = {ring_slot(item_slot_q, back_new), item_pos_q};
    addr_old = {ring_slot(item_slot_q, back_old), item_pos_q};
    old_ok   = back_old <= item_fr_q;
  end

  // Frame ring: written on accept, two registered read ports
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      frame_history[{slot_q, pos_eff}] <= in_sample_i;
    end
    if (cmd_i.rd_en) begin
      rd_new_q <= frame_history[addr_new];
      rd_old_q <= frame_history[addr_old];
      old_ok_q <= old_ok;
    end
  end

  // Multiply-accumulate of one tap
  logic signed [SAMPLE_BITS-1:0] older;
  logic signed [SAMPLE_BITS:0]   diff;
  logic signed [PROD_W-1:0]      prod;
  logic signed [ACC_W-1:0]       acc_d;

  always_comb begin
    older = old_ok_q ? rd_old_q : '0;
    diff  = {rd_new_q[SAMPLE_BITS-1], rd_new_q} - {older[SAMPLE_BITS-1], older};
    prod  = PROD_W'($signed({1'b0, tap_q})) * PROD_W'(diff);
    acc_d = acc_q + ACC_W'(prod);
  end

  // Restoring divider on the magnitude, one quotient bit per cycle
  logic [DIV_W-1:0] divisor;
  logic [ACC_W-1:0] mag;
  logic [DIV_W:0]   part;
  logic [DIV_W:0]   trial;

  always_comb begin
    divisor = DIV_W'(drc_pkg::tap_norm(32'(n_q)));
    mag     = acc_q[ACC_W-1] ? -acc_q : acc_q;
    part    = {rem_q, quo_q[SAMPLE_BITS-1]};
    trial   = part - {1'b0, divisor};
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      acc_q <= '0;
    end else if (cmd_i.mac_en) begin
      acc_q <= acc_d;
    end
    if (cmd_i.div_prep) begin
      rem_q <= DIV_W'(mag >> SAMPLE_BITS);
      quo_q <= mag[SAMPLE_BITS-1:0];
      neg_q <= acc_q[ACC_W-1];
    end else if (cmd_i.div_step) begin
      if (!trial[DIV_W]) begin
        rem_q <= trial[DIV_W-1:0];
        quo_q <= {quo_q[SAMPLE_BITS-2:0], 1'b1};
      end else begin
        rem_q <= part[DIV_W-1:0];
        quo_q <= {quo_q[SAMPLE_BITS-2:0], 1'b0};
      end
    end
  end

  // Sign, window-zero bypass and saturation
  logic signed [SAMPLE_BITS:0]   quo_s;
  logic signed [ACC_W-1:0]       res_wide;
  logic signed [SAMPLE_BITS-1:0] res_sat;

  always_comb begin
    quo_s    = neg_q ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});
    res_wide = (n_q == '0) ? acc_q : ACC_W'(quo_s);
    if (res_wide > SAT_HI) begin
      res_sat = SAT_HI[SAMPLE_BITS-1:0];
    end else if (res_wide < SAT_LO) begin
      res_sat = SAT_LO[SAMPLE_BITS-1:0];
    end else begin
      res_sat = res_wide[SAMPLE_BITS-1:0];
    end
  end

  // Output register
  logic out_free;
  assign out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_delta_q <= res_sat;
      out_index_q <= drc_pkg::IDX_W'(item_pos_q);
      out_last_q  <= item_last_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_delta_o = out_delta_q;
  assign out_index_o = out_index_q;
  assign out_last_o  = out_last_q;

  assign status_o.item_emit = emit;
  assign status_o.n_zero    = (n_q == '0);
  assign status_o.tap_last  = tap_last;
  assign status_o.out_free  = out_free;

`ifndef ASSERT_OFF
  // Partial remainder stays below the divisor while dividing
  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.div_step |-> (rem_q < divisor))
    else $error("divider remainder out of range");

  // Frame count saturates at twice the largest half window
  a_fr_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fr_q <= FR_W'(2 * MAX_HALF_WINDOW))
    else $error("frame count above its limit");

  // Ring pointer never leaves the ring
  a_slot_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    slot_q < SLOT_W'(RING))
    else $error("ring slot out of range");
`endif

endmodule

`default_nettype wire

// File: dv/delta_regression_coefficients_test.sv
// Self-checking testbench for delta_regression_coefficients: a directed opening,
// then random coefficient streams under several register settings, checked per beat.
// Depends on drc_pkg and the RTL of delta_regression_coefficients only.
`timescale 1ns / 1ps

module delta_regression_coefficients_test;

  import drc_pkg::*;

  localparam int RING_DEPTH  = 2 * MAX_HALF_WINDOW_DEF + 1;
  localparam int COEFF_SLOTS = MAX_COEFFS_DEF;
  localparam int ITEM_TARGET = 1750;
  localparam int CALM_TAIL   = 250;
  // covers the longest item at n = 4, plus margin
  localparam int HOLD_OFF    = 2 * MAX_HALF_WINDOW_DEF + SAMPLE_BITS_DEF + 8;

  // one delta beat as seen on the output stream
  typedef struct packed {
    logic [15:0] value;
    logic [5:0]  index;
    logic        frame_end;
  } delta_beat_t;

  // Tracks the ring of recent frames and the deltas still owed by the block
  class delta_tracker;
    logic signed [15:0] ring [RING_DEPTH][COEFF_SLOTS];
    int                 coeff_pos;
    int                 newest_slot;
    int                 frames_seen;
    logic [2:0]         half_window;
    logic [6:0]         frame_len;
    delta_beat_t        deltas_due[$];
    int                 accepted;
    int                 delivered;
    int                 failures;

    function new();
      coeff_pos   = 0;
      newest_slot = 0;
      frames_seen = 0;
      half_window = WIN_RESET;
      frame_len   = COEFFS_RESET;
      accepted    = 0;
      delivered   = 0;
      failures    = 0;
    endfunction

    function int eff_len();
      if (frame_len == 0) return 1;
      if (frame_len > COEFF_SLOTS) return COEFF_SLOTS;
      return int'(frame_len);
    endfunction

    function int eff_window();
      return (half_window > MAX_HALF_WINDOW_DEF) ? MAX_HALF_WINDOW_DEF : int'(half_window);
    endfunction

    function int pending();
      return deltas_due.size();
    endfunction

    function void write_reg(cfg_reg_e r, logic [6:0] v);
      case (r)
        REG_WINDOW: half_window = v[2:0];
        REG_COEFFS: frame_len   = v;
        default: ;
      endcase
    endfunction

    // coefficient `back` frames before the newest one
    function longint tap(int back, int p);
      return ring[(newest_slot + RING_DEPTH - back) % RING_DEPTH][p];
    endfunction

    function void report(string msg);
      failures++;
      if (failures <= 10) $display("mismatch: %s", msg);
    endfunction

    // Take one accepted coefficient beat and work out the delta it owes, if any
    function void note_coeff(logic [15:0] sample, bit sos);
      int          n;
      int          len;
      int          p;
      int          k;
      longint      acc;
      longint      wsum;
      longint      q;
      longint      older;
      bit          closes;
      bit          gives;
      delta_beat_t beat;
      n = eff_window();
      len = eff_len();
      accepted++;
      if (sos) begin
        coeff_pos   = 0;
        frames_seen = 0;
      end
      p = coeff_pos;
      closes = (p + 1 >= len);
      ring[newest_slot][p] = sample;
      gives = 1'b0;
      q = 0;
      if (n == 0) begin
        // first difference; absent previous frame reads as zero
        older = (frames_seen >= 1) ? tap(1, p) : 64'sd0;
        q = tap(0, p) - older;
        gives = 1'b1;
      end else if (frames_seen >= n) begin
        acc  = 0;
        wsum = 0;
        for (k = 1; k <= n; k++) begin
          older = (n + k <= frames_seen) ? tap(n + k, p) : 64'sd0;
          acc  += longint'(k) * (tap(n - k, p) - older);
          wsum += longint'(k * k);
        end
        q = acc / (2 * wsum);
        gives = 1'b1;
      end
      if (closes) begin
        coeff_pos   = 0;
        newest_slot = (newest_slot + 1) % RING_DEPTH;
        if (frames_seen < 2 * MAX_HALF_WINDOW_DEF) frames_seen++;
      end else begin
        coeff_pos = p + 1;
      end
      if (gives) begin
        if (q > 32767) q = 32767;
        if (q < -32768) q = -32768;
        beat.value     = q[15:0];
        beat.index     = p[5:0];
        beat.frame_end = closes;
        deltas_due.push_back(beat);
      end
    endfunction

    // Compare one delivered delta beat with the oldest one owed
    function void check_delta(delta_beat_t got);
      delta_beat_t want;
      if (deltas_due.size() == 0) begin
        report($sformatf("delta beat with none owed: value %h index %0d end %0b",
                         got.value, got.index, got.frame_end));
        return;
      end
      want = deltas_due.pop_front();
      delivered++;
      if (got.value !== want.value || got.index !== want.index ||
          got.frame_end !== want.frame_end) begin
        report($sformatf("expected value %h index %0d end %0b, got value %h index %0d end %0b",
                         want.value, want.index, want.frame_end,
                         got.value, got.index, got.frame_end));
      end
    endfunction
  endclass

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [CFG_ADDR_W-1:0] cfg_addr_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [15:0]           s_axis_tdata;   // sample_value
  logic                  s_axis_tuser;   // start_of_stream
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [15:0]           m_axis_tdata;   // delta_value
  logic [IDX_W-1:0]      m_axis_tuser;   // coeff_index
  logic                  m_axis_tlast;   // frame_end

  delta_tracker board;
  bit           restart_due;
  bit           quiet_tail;
  int           send_idle_pct;
  int           recv_idle_pct;
  int           settings;

  delta_regression_coefficients uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  // 50 MHz clock
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Hard limit on run length
  initial begin
    #20_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // Mixed coefficient values: extremes, small Q8.8 values and full-range noise
  function automatic logic [15:0] pick_coeff();
    logic [15:0] v;
    case ($urandom_range(0, 9))
      0:       v = 16'h7FFF;
      1:       v = 16'h8000;
      2:       v = 16'h0000;
      3, 4:    v = 16'($urandom_range(0, 1023)) - 16'd512;
      default: v = 16'($urandom);
    endcase
    return v;
  endfunction

  // One coefficient beat, with an optional idle burst ahead of it
  task automatic send_coeff(logic [15:0] value, bit sos);
    int gap;
    if (board.accepted >= ITEM_TARGET - CALM_TAIL) quiet_tail = 1'b1;
    if (!quiet_tail && $urandom_range(0, 99) < send_idle_pct) begin
      gap = $urandom_range(1, 19);
      repeat (gap) begin
        @(negedge clk_i);
        s_axis_tvalid = 1'b0;
      end
    end
    @(negedge clk_i);
    if (restart_due) begin
      sos = 1'b1;
      restart_due = 1'b0;
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = value;
    s_axis_tuser  = sos;
    do @(posedge clk_i); while (!s_axis_tready);
    board.note_coeff(value, sos);
  endtask

  // Stop sending and wait until every owed delta has come out
  task automatic wait_drained();
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
    repeat (HOLD_OFF) @(posedge clk_i);
  endtask

  // Register write while the block is idle
  task automatic set_reg(cfg_reg_e r, logic [6:0] v);
    int old_len;
    wait_drained();
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_addr_i  = r;
    cfg_data_i  = v;
    do @(posedge clk_i); while (!cfg_ready_o);
    old_len = board.eff_len();
    board.write_reg(r, v);
    // older frames lack the new positions, so the next beat opens a fresh stream
    if (board.eff_len() > old_len) restart_due = 1'b1;
    settings++;
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // Output side: ready with random stall bursts
  initial begin
    int stall_left;
    stall_left    = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (stall_left > 0) begin
        m_axis_tready = 1'b0;
        stall_left--;
      end else begin
        m_axis_tready = 1'b1;
        if (!quiet_tail && $urandom_range(0, 99) < recv_idle_pct)
          stall_left = $urandom_range(1, 19);
      end
    end
  end

  // Check every delta beat taken from the block
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      board.check_delta('{value: m_axis_tdata, index: m_axis_tuser, frame_end: m_axis_tlast});
  end

  initial begin
    int  frames;
    int  len;
    int  n;
    int  k;
    int  cut;
    int  phase_items;
    bit  broken;
    bit  truncate;
    bit  first_phase;
    bit  paused;
    logic [6:0] win_raw;
    logic [6:0] len_raw;
    board         = new();
    restart_due   = 1'b0;
    quiet_tail    = 1'b0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    settings      = 0;
    cfg_valid_i   = 1'b0;
    cfg_addr_i    = REG_WINDOW;
    cfg_data_i    = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = 1'b0;
    rst_ni        = 1'b0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // First difference with saturating extremes; first frame gives c[t] itself
    set_reg(REG_WINDOW, 7'd0);
    set_reg(REG_COEFFS, 7'd3);
    send_coeff(16'h7FFF, 1'b1);
    send_coeff(16'h8000, 1'b0);
    send_coeff(16'h0000, 1'b0);
    send_coeff(16'h8000, 1'b0);
    send_coeff(16'h7FFF, 1'b0);
    send_coeff(16'h0001, 1'b0);

    // Frame size shrunk mid frame: the next beat ends the frame at position 3
    set_reg(REG_COEFFS, 7'd5);
    send_coeff(16'h0100, 1'b0);
    send_coeff(16'h0200, 1'b0);
    send_coeff(16'h0300, 1'b0);
    set_reg(REG_COEFFS, 7'd2);
    send_coeff(16'h0400, 1'b0);
    send_coeff(16'h0005, 1'b0);

    // Window above the maximum, frame size zero, a too-early stretch and a restart
    set_reg(REG_WINDOW, 7'h7F);
    set_reg(REG_COEFFS, 7'd0);
    send_coeff(16'h7FFF, 1'b1);
    send_coeff(16'h8000, 1'b0);
    send_coeff(16'h7FFF, 1'b0);
    send_coeff(16'h8000, 1'b0);
    send_coeff(16'h7FFF, 1'b0);
    send_coeff(16'hFFFF, 1'b0);
    send_coeff(16'h8000, 1'b1);
    send_coeff(16'h7FFF, 1'b0);
    send_coeff(16'h8000, 1'b0);
    send_coeff(16'h7FFF, 1'b0);
    send_coeff(16'h8000, 1'b0);
    send_coeff(16'h0000, 1'b0);

    // Random phases, each under a fresh register setting
    first_phase = 1'b1;
    paused      = 1'b0;
    while (board.accepted < ITEM_TARGET) begin
      if (first_phase) begin
        win_raw = 7'd4;
        len_raw = 7'd127;
      end else begin
        win_raw = 7'($urandom_range(0, 127));
        case ($urandom_range(0, 9))
          0:       len_raw = 7'd0;
          1:       len_raw = 7'($urandom_range(17, 63));
          2:       len_raw = 7'($urandom_range(64, 127));
          default: len_raw = 7'($urandom_range(1, 16));
        endcase
      end
      if ($urandom_range(0, 1)) begin
        set_reg(REG_WINDOW, win_raw);
        set_reg(REG_COEFFS, len_raw);
      end else begin
        set_reg(REG_COEFFS, len_raw);
        set_reg(REG_WINDOW, win_raw);
      end
      first_phase = 1'b0;
      case ($urandom_range(0, 3))
        0:       send_idle_pct = 0;
        1:       send_idle_pct = 10;
        2:       send_idle_pct = 30;
        default: send_idle_pct = 60;
      endcase
      case ($urandom_range(0, 3))
        0:       recv_idle_pct = 0;
        1:       recv_idle_pct = 10;
        2:       recv_idle_pct = 30;
        default: recv_idle_pct = 60;
      endcase
      phase_items = 0;
      while (phase_items < 90 + 3 * board.eff_len() && board.accepted < ITEM_TARGET) begin
        len      = board.eff_len();
        n        = board.eff_window();
        frames   = $urandom_range(1, (len > 16) ? 3 : 10);
        // most streams are whole; some restart or stop part way
        broken   = ($urandom_range(0, 5) == 0);
        truncate = $urandom_range(0, 1);
        cut      = broken ? $urandom_range(1, frames * len) : -1;
        for (k = 0; k < frames * len; k++) begin
          if (k == cut && truncate) break;
          send_coeff(pick_coeff(), (k == 0) || (k == cut));
          phase_items++;
        end
        if (!(broken && truncate)) begin
          // end padding: one zero frame per context frame
          for (k = 0; k < n * len; k++) begin
            send_coeff(16'h0000, 1'b0);
            phase_items++;
          end
        end
        if (!paused && board.accepted > ITEM_TARGET / 2) begin
          wait_drained();
          paused = 1'b1;
        end
      end
    end

    // Drain and let any stray beat show itself
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
    repeat (HOLD_OFF + 20) @(posedge clk_i);

    $display("Run covered %0d coefficient beats and %0d delta beats over %0d register writes",
             board.accepted, board.delivered, settings);
    $display("Half windows 0 to 7 and frame sizes 0 to 127 exercised, %0d failures",
             board.failures);
    if (board.failures == 0 && board.pending() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
